[design/mnfn_pkg.sv]
// ----------------------------------------------------------------------------
// mnfn_pkg
// Shared types and codes for the mesh normaliser and face-normal block.
// ----------------------------------------------------------------------------
package mnfn_pkg;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_BOUNDS = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_NORMAL = 2'd1;
  localparam logic [1:0] KIND_BMIN   = 2'd2;
  localparam logic [1:0] KIND_BMAX   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ZERO  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W  = 48;
  localparam int DEN_W  = 32;
  localparam int QUO_W  = 15;

  localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [7:0]         tri_index;
  } mnfn_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [1:0]         status;
    logic               last;
  } mnfn_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  function automatic logic signed [15:0] comp_of(vec_t v, logic [1:0] j);
    logic signed [15:0] c;
    case (j)
      2'd0:    c = v.x;
      2'd1:    c = v.y;
      default: c = v.z;
    endcase
    return c;
  endfunction

endpackage

[design/mnfn_vstore.sv]
// ----------------------------------------------------------------------------
// mnfn_vstore
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mnfn_vstore #(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  mnfn_pkg::vec_t   wdata,
  input  logic [AW-1:0]    raddr,
  output mnfn_pkg::vec_t   rdata
);
  import mnfn_pkg::*;

  vec_t mem [DEPTH];
  vec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/mnfn_isqrt.sv]
// ----------------------------------------------------------------------------
// mnfn_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mnfn_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mnfn_pkg::sqrt_req_t         req,
  output logic                        busy,
  output logic [mnfn_pkg::ROOT_W-1:0] root
);
  import mnfn_pkg::*;

  localparam int STEPS = RAD_W / 2;
  localparam int SCW   = $clog2(STEPS + 1);

  logic [RAD_W-1:0] x_r, x_nxt, r_r, r_nxt, bit_r, bit_nxt, trial;
  logic [SCW-1:0]   cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  always_comb begin
    trial    = r_r + bit_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      x_nxt    = req.rad;
      r_nxt    = '0;
      bit_nxt  = {2'b01, {(RAD_W-2){1'b0}}};
      cnt_nxt  = SCW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt  = bit_r >> 2;
      cnt_nxt  = cnt_r - SCW'(1);
      busy_nxt = (cnt_r != SCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

[design/mnfn_div.sv]
// ----------------------------------------------------------------------------
// mnfn_div
// Restoring divider with round half away from zero, saturation and sign.
// ----------------------------------------------------------------------------
module mnfn_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mnfn_pkg::div_req_t  req,
  output logic                busy,
  output logic signed [15:0]  quo
);
  import mnfn_pkg::*;

  localparam int DCW = $clog2(QUO_W + 1);

  logic [NUM_W-1:0] rem_r, rem_nxt, d_r, d_nxt;
  logic [QUO_W-1:0] q_r, q_nxt, qs;
  logic [DCW-1:0]   cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt, busy_r, busy_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = req.num + NUM_W'(req.den >> 1);
      d_nxt    = NUM_W'(req.den) << (QUO_W - 1);
      q_nxt    = '0;
      neg_nxt  = req.neg;
      cnt_nxt  = DCW'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= d_r) begin
        rem_nxt = rem_r - d_r;
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
      d_nxt    = d_r >> 1;
      cnt_nxt  = cnt_r - DCW'(1);
      busy_nxt = (cnt_r != DCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign qs   = (q_r > ONE_Q14) ? ONE_Q14 : q_r;
  assign quo  = neg_r ? -$signed(16'(qs)) : $signed(16'(qs));
  assign busy = busy_r;

endmodule

[design/mesh_normalize_and_face_normals.sv]
// ----------------------------------------------------------------------------
// mesh_normalize_and_face_normals
// Loads triangle vertices into a store and answers scaled-vertex, face-normal
// and bounding-box queries in signed Q1.14.
//
//   channel  dir  transaction
//   in_      in   mnfn_in_t   load / triangle query / bounds query / clear
//   out_     out  mnfn_out_t  one scaled vector, normal or corner
//
// A bounds or triangle query is computed with the 32-step square-root unit and
// the 15-step divider; the divider serves every component in turn.
// One transaction is in work at a time; in_ready is high only when idle.
// A stalled result holds in the output register and stops the sequencer.
// Reset is synchronous and empties the mesh; the store itself is not cleared.
// ----------------------------------------------------------------------------
module mesh_normalize_and_face_normals #(
  parameter int MAX_TRIANGLES = 256,
  parameter int COORD_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mnfn_pkg::mnfn_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mnfn_pkg::mnfn_out_t out_data
);
  import mnfn_pkg::*;

  localparam int VCAP   = MAX_TRIANGLES * 3;
  localparam int AW     = (VCAP > 1) ? $clog2(VCAP) : 1;
  localparam int CNTW   = $clog2(VCAP + 1);
  localparam int XW     = (CNTW > 10) ? CNTW + 1 : 11;
  localparam int CW     = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int CSH    = 16 - CW;
  localparam int MUL_W  = 21;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CR_W   = 35;
  localparam int MAG_W  = 34;
  localparam int ACC_W  = 42;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LSQ   = 5'd1;
  localparam logic [4:0] S_LMAX  = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_WAITL = 5'd4;
  localparam logic [4:0] S_SDIV  = 5'd5;
  localparam logic [4:0] S_SDW   = 5'd6;
  localparam logic [4:0] S_XDIF  = 5'd7;
  localparam logic [4:0] S_XMUL  = 5'd8;
  localparam logic [4:0] S_XABS  = 5'd9;
  localparam logic [4:0] S_XSH   = 5'd10;
  localparam logic [4:0] S_XSQ   = 5'd11;
  localparam logic [4:0] S_NSQ   = 5'd12;
  localparam logic [4:0] S_NWT   = 5'd13;
  localparam logic [4:0] S_NDIV  = 5'd14;
  localparam logic [4:0] S_NDW   = 5'd15;
  localparam logic [4:0] S_EMIT  = 5'd16;

  function automatic logic signed [15:0] coord_ext(logic [15:0] raw);
    logic signed [15:0] s;
    s = signed'(raw << CSH);
    return s >>> CSH;
  endfunction

  logic [4:0]              state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [1:0]              k_r, k_nxt, j_r, j_nxt;
  logic                    tri_r, tri_nxt;
  logic [CNTW-1:0]         vcount_r, vcount_nxt;
  logic [31:0]             msq_r, msq_nxt;
  vec_t                    blo_r, blo_nxt, bhi_r, bhi_nxt;
  vec_t                    vtx_r [3];
  vec_t                    vtx_nxt [3];
  logic signed [15:0]      res_r [3];
  logic signed [15:0]      res_nxt [3];
  logic [ROOT_W-1:0]       len_r, len_nxt, nrm_r, nrm_nxt;
  logic signed [16:0]      da_r [3];
  logic signed [16:0]      da_nxt [3];
  logic signed [16:0]      db_r [3];
  logic signed [16:0]      db_nxt [3];
  logic signed [CR_W-1:0]  cr_r [3];
  logic signed [CR_W-1:0]  cr_nxt [3];
  logic [MAG_W-1:0]        m_r [3];
  logic [MAG_W-1:0]        m_nxt [3];
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [AW-1:0]           base_r, base_nxt;
  mnfn_out_t               em_r, em_nxt;
  logic                    out_valid_r, out_valid_nxt;
  mnfn_out_t               out_data_r, out_data_nxt;

  vec_t                    cin, vrd;
  logic                    we;
  logic [AW-1:0]           raddr;
  logic [XW-1:0]           t3;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [15:0]      csel;
  logic [15:0]             cmag;
  logic                    sc_done;
  sqrt_req_t               sq_req;
  div_req_t                dv_req;
  logic                    sq_busy, dv_busy;
  logic [ROOT_W-1:0]       sq_root;
  logic signed [15:0]      dv_quo;

  mnfn_vstore #(.DEPTH(VCAP), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (vcount_r[AW-1:0]),
    .wdata (cin),
    .raddr (raddr),
    .rdata (vrd)
  );

  mnfn_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  mnfn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dv_req),
    .busy  (dv_busy),
    .quo   (dv_quo)
  );

  assign cin.x = coord_ext(in_data.coord_x);
  assign cin.y = coord_ext(in_data.coord_y);
  assign cin.z = coord_ext(in_data.coord_z);
  assign t3    = XW'({in_data.tri_index, 1'b0}) + XW'(in_data.tri_index);
  assign prod  = mul_a * mul_b;
  assign csel  = comp_of(vtx_r[k_r], j_r);
  assign cmag  = csel[15] ? 16'(-csel) : 16'(csel);
  assign raddr = base_r + AW'(cnt_r);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    tri_nxt    = tri_r;
    vcount_nxt = vcount_r;
    msq_nxt    = msq_r;
    blo_nxt    = blo_r;
    bhi_nxt    = bhi_r;
    vtx_nxt    = vtx_r;
    res_nxt    = res_r;
    len_nxt    = len_r;
    nrm_nxt    = nrm_r;
    da_nxt     = da_r;
    db_nxt     = db_r;
    cr_nxt     = cr_r;
    m_nxt      = m_r;
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    em_nxt     = em_r;
    we         = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sc_done    = 1'b0;
    sq_req     = '0;
    dv_req     = '0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FUNC_LOAD: begin
              if (vcount_r < CNTW'(VCAP)) begin
                we = 1'b1;
                if (vcount_r == '0 || cin.x < blo_r.x) blo_nxt.x = cin.x;
                if (vcount_r == '0 || cin.y < blo_r.y) blo_nxt.y = cin.y;
                if (vcount_r == '0 || cin.z < blo_r.z) blo_nxt.z = cin.z;
                if (vcount_r == '0 || cin.x > bhi_r.x) bhi_nxt.x = cin.x;
                if (vcount_r == '0 || cin.y > bhi_r.y) bhi_nxt.y = cin.y;
                if (vcount_r == '0 || cin.z > bhi_r.z) bhi_nxt.z = cin.z;
                vcount_nxt = vcount_r + CNTW'(1);
                vtx_nxt[0] = cin;
                acc_nxt    = '0;
                cnt_nxt    = '0;
                state_nxt  = S_LSQ;
              end
            end
            FUNC_CLEAR: begin
              vcount_nxt = '0;
              msq_nxt    = '0;
              blo_nxt    = '0;
              bhi_nxt    = '0;
            end
            FUNC_BOUNDS: begin
              tri_nxt       = 1'b0;
              vtx_nxt[0]    = blo_r;
              vtx_nxt[1]    = bhi_r;
              sq_req.start  = 1'b1;
              sq_req.rad    = {msq_r, 32'b0};
              k_nxt         = '0;
              j_nxt         = '0;
              state_nxt     = S_WAITL;
            end
            default: begin
              if (t3 + XW'(3) > XW'(vcount_r)) begin
                em_nxt    = '{kind: KIND_VERTEX, out_x: '0, out_y: '0, out_z: '0,
                              status: STAT_RANGE, last: 1'b1};
                ret_nxt   = S_IDLE;
                state_nxt = S_EMIT;
              end else begin
                tri_nxt      = 1'b1;
                base_nxt     = t3[AW-1:0];
                cnt_nxt      = '0;
                sq_req.start = 1'b1;
                sq_req.rad   = {msq_r, 32'b0};
                state_nxt    = S_RD;
              end
            end
          endcase
        end
      end
      S_LSQ: begin
        mul_a   = MUL_W'(comp_of(vtx_r[0], cnt_r[1:0]));
        mul_b   = mul_a;
        acc_nxt = acc_r + unsigned'(prod);
        if (cnt_r == 3'd2) begin
          state_nxt = S_LMAX;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_LMAX: begin
        if (acc_r > ACC_W'(msq_r)) msq_nxt = acc_r[31:0];
        state_nxt = S_IDLE;
      end
      S_RD: begin
        if (cnt_r != 3'd0) vtx_nxt[cnt_r[1:0] - 2'd1] = vrd;
        if (cnt_r == 3'd3) begin
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_WAITL;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WAITL: begin
        if (!sq_busy) begin
          len_nxt   = sq_root;
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        if (msq_r == '0) begin
          res_nxt[j_r] = '0;
          sc_done      = 1'b1;
        end else begin
          dv_req.start = 1'b1;
          dv_req.neg   = csel[15];
          dv_req.num   = NUM_W'(cmag) << 30;
          dv_req.den   = len_r;
          state_nxt    = S_SDW;
        end
      end
      S_SDW: begin
        if (!dv_busy) begin
          res_nxt[j_r] = dv_quo;
          sc_done      = 1'b1;
        end
      end
      S_XDIF: begin
        for (int i = 0; i < 3; i++) begin
          da_nxt[i] = 17'(comp_of(vtx_r[0], 2'(i))) - 17'(comp_of(vtx_r[1], 2'(i)));
          db_nxt[i] = 17'(comp_of(vtx_r[0], 2'(i))) - 17'(comp_of(vtx_r[2], 2'(i)));
        end
        cnt_nxt   = '0;
        state_nxt = S_XMUL;
      end
      S_XMUL: begin
        case (cnt_r)
          3'd0:    begin mul_a = MUL_W'(da_r[1]); mul_b = MUL_W'(db_r[2]); end
          3'd1:    begin mul_a = MUL_W'(da_r[2]); mul_b = MUL_W'(db_r[1]); end
          3'd2:    begin mul_a = MUL_W'(da_r[2]); mul_b = MUL_W'(db_r[0]); end
          3'd3:    begin mul_a = MUL_W'(da_r[0]); mul_b = MUL_W'(db_r[2]); end
          3'd4:    begin mul_a = MUL_W'(da_r[0]); mul_b = MUL_W'(db_r[1]); end
          default: begin mul_a = MUL_W'(da_r[1]); mul_b = MUL_W'(db_r[0]); end
        endcase
        if (!cnt_r[0]) begin
          cr_nxt[cnt_r[2:1]] = CR_W'(prod);
        end else begin
          cr_nxt[cnt_r[2:1]] = cr_r[cnt_r[2:1]] - CR_W'(prod);
        end
        if (cnt_r == 3'd5) begin
          state_nxt = S_XABS;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_XABS: begin
        for (int i = 0; i < 3; i++) begin
          m_nxt[i] = cr_r[i][CR_W-1] ? MAG_W'(-cr_r[i]) : MAG_W'(cr_r[i]);
        end
        if (cr_r[0] == '0 && cr_r[1] == '0 && cr_r[2] == '0) begin
          em_nxt    = '{kind: KIND_NORMAL, out_x: '0, out_y: '0, out_z: '0,
                        status: STAT_ZERO, last: 1'b1};
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_XSH;
        end
      end
      S_XSH: begin
        if (m_r[0][MAG_W-1:20] != '0 || m_r[1][MAG_W-1:20] != '0 ||
            m_r[2][MAG_W-1:20] != '0) begin
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] >> 1;
        end else begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_XSQ;
        end
      end
      S_XSQ: begin
        mul_a   = MUL_W'({1'b0, m_r[cnt_r[1:0]][19:0]});
        mul_b   = mul_a;
        acc_nxt = acc_r + unsigned'(prod);
        if (cnt_r == 3'd2) begin
          state_nxt = S_NSQ;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_NSQ: begin
        sq_req.start = 1'b1;
        sq_req.rad   = RAD_W'(acc_r) << 20;
        state_nxt    = S_NWT;
      end
      S_NWT: begin
        if (!sq_busy) begin
          nrm_nxt = sq_root;
          if (sq_root == '0) begin
            em_nxt    = '{kind: KIND_NORMAL, out_x: '0, out_y: '0, out_z: '0,
                          status: STAT_ZERO, last: 1'b1};
            ret_nxt   = S_IDLE;
            state_nxt = S_EMIT;
          end else begin
            j_nxt     = '0;
            state_nxt = S_NDIV;
          end
        end
      end
      S_NDIV: begin
        dv_req.start = 1'b1;
        dv_req.neg   = cr_r[j_r][CR_W-1];
        dv_req.num   = NUM_W'(m_r[j_r][19:0]) << 24;
        dv_req.den   = nrm_r;
        state_nxt    = S_NDW;
      end
      S_NDW: begin
        if (!dv_busy) begin
          res_nxt[j_r] = dv_quo;
          if (j_r == 2'd2) begin
            em_nxt    = '{kind: KIND_NORMAL, out_x: res_nxt[0], out_y: res_nxt[1],
                          out_z: res_nxt[2], status: STAT_OK, last: 1'b1};
            ret_nxt   = S_IDLE;
            state_nxt = S_EMIT;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = S_NDIV;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = em_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (sc_done) begin
      if (j_r == 2'd2) begin
        em_nxt.kind   = tri_r ? KIND_VERTEX : ((k_r == 2'd0) ? KIND_BMIN : KIND_BMAX);
        em_nxt.out_x  = res_nxt[0];
        em_nxt.out_y  = res_nxt[1];
        em_nxt.out_z  = res_nxt[2];
        em_nxt.status = (msq_r == '0) ? STAT_ZERO : STAT_OK;
        em_nxt.last   = !tri_r && (k_r == 2'd1);
        if (tri_r) begin
          ret_nxt = (k_r == 2'd2) ? S_XDIF : S_SDIV;
        end else begin
          ret_nxt = (k_r == 2'd1) ? S_IDLE : S_SDIV;
        end
        k_nxt     = k_r + 2'd1;
        j_nxt     = '0;
        state_nxt = S_EMIT;
      end else begin
        j_nxt     = j_r + 2'd1;
        state_nxt = S_SDIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      msq_r       <= '0;
      blo_r       <= '0;
      bhi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      msq_r       <= msq_nxt;
      blo_r       <= blo_nxt;
      bhi_r       <= bhi_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r      <= ret_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    tri_r      <= tri_nxt;
    vtx_r      <= vtx_nxt;
    res_r      <= res_nxt;
    len_r      <= len_nxt;
    nrm_r      <= nrm_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    cr_r       <= cr_nxt;
    m_r        <= m_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    em_r       <= em_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CNTW'(VCAP))
    else $error("vertex count beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_CLEAR |=> vcount_r == '0 && msq_r == '0)
    else $error("clear did not empty the mesh");

  a_range_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_RANGE |-> out_data.last &&
      out_data.kind == KIND_VERTEX)
    else $error("out-of-range result not final");

  a_bmax_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_BMAX || out_data.kind == KIND_NORMAL)
      |-> out_data.last)
    else $error("closing result without last");
`endif

endmodule
